[hw/rtl/bcc_pkg.sv]
// Package for the button click classifier: widths, codes and the structs
// passed between the top level and the classifier core. No dependencies.

package bcc_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Reset values of the configuration registers
  localparam logic [TimerW-1:0] DebounceReset = TimerW'(2);
  localparam logic [TimerW-1:0] LongReset     = TimerW'(100);
  localparam logic [TimerW-1:0] SettleReset   = TimerW'(30);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_CLICK  = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_SETTLE   = 2'd2
  } reg_idx_e;

  // Configuration as seen by the core
  typedef struct packed {
    logic [TimerW-1:0] debounce_period;
    logic [TimerW-1:0] long_press_ticks;
    logic [TimerW-1:0] settle_ticks;
  } cfg_t;

  // One input transaction
  typedef struct packed {
    logic       op;
    logic       pin_level;
    logic [1:0] event_select;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic event_seen;
    logic pressed;
    logic click_pending;
    logic double_pending;
    logic long_pending;
  } res_t;

  // Saturating timer increment
  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    logic [TimerW-1:0] r;
    r = (v == TimerMax) ? TimerMax : v + TimerW'(1);
    return r;
  endfunction

endpackage

[hw/rtl/bcc_if.sv]
// Valid/ready channel interfaces for the button click classifier:
// input items, results and configuration writes. Depends on bcc_pkg.

interface bcc_in_if import bcc_pkg::*;;
  logic       valid;
  logic       ready;
  logic       op;
  logic       pin_level;
  logic [1:0] event_select;

  modport source (output valid, output op, output pin_level, output event_select,
                  input ready);
  modport sink   (input valid, input op, input pin_level, input event_select,
                  output ready);
endinterface

interface bcc_out_if import bcc_pkg::*;;
  logic valid;
  logic ready;
  logic event_seen;
  logic pressed;
  logic click_pending;
  logic double_pending;
  logic long_pending;

  modport source (output valid, output event_seen, output pressed,
                  output click_pending, output double_pending, output long_pending,
                  input ready);
  modport sink   (input valid, input event_seen, input pressed,
                  input click_pending, input double_pending, input long_pending,
                  output ready);
endinterface

interface bcc_cfg_if import bcc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimerW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bcc_core.sv]
// Classifier core: debounce state, press/release timers, press count and
// sticky event flags, updated once per stepped transaction. Uses bcc_pkg.

module bcc_core import bcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [TimerW-1:0] sample_timer_q, sample_timer_d;
  logic              last_level_q, last_level_d;
  logic              pressed_q, pressed_d;
  logic [CountW-1:0] count_q, count_d;
  logic              click_q, click_d;
  logic              double_q, double_d;
  logic              long_q, long_d;
  logic [TimerW-1:0] press_timer_q, press_timer_d;
  logic [TimerW-1:0] release_timer_q, release_timer_d;
  logic              seen;
  logic [TimerW-1:0] st_inc;

  // Next state for one transaction
  always_comb begin
    sample_timer_d  = sample_timer_q;
    last_level_d    = last_level_q;
    pressed_d       = pressed_q;
    count_d         = count_q;
    click_d         = click_q;
    double_d        = double_q;
    long_d          = long_q;
    press_timer_d   = press_timer_q;
    release_timer_d = release_timer_q;
    seen            = 1'b0;
    st_inc          = sat_inc(sample_timer_q);

    if (item_i.op == OP_TICK) begin
      // Sample the pin once the debounce period has run out
      sample_timer_d = st_inc;
      if (st_inc > cfg_i.debounce_period) begin
        if (item_i.pin_level != last_level_q) begin
          last_level_d = item_i.pin_level;
          pressed_d    = !item_i.pin_level;
          if (!item_i.pin_level && count_q != CountMax) begin
            count_d = count_q + CountW'(1);
          end
        end
        sample_timer_d = '0;
      end
      // Time the press or the release
      if (pressed_d) begin
        if (press_timer_q == cfg_i.long_press_ticks) begin
          long_d  = 1'b1;
          count_d = '0;
        end
        press_timer_d   = sat_inc(press_timer_q);
        release_timer_d = '0;
      end else begin
        if (release_timer_q > cfg_i.settle_ticks && !long_q) begin
          if (count_d == CountW'(1)) begin
            click_d = 1'b1;
          end else if (count_d == CountW'(2)) begin
            double_d = 1'b1;
          end
          count_d = '0;
        end
        press_timer_d   = '0;
        release_timer_d = sat_inc(release_timer_q);
      end
    end else begin
      // Read and clear one sticky flag
      case (item_i.event_select)
        EV_CLICK: begin
          seen    = click_q;
          click_d = 1'b0;
        end
        EV_DOUBLE: begin
          seen     = double_q;
          double_d = 1'b0;
        end
        EV_LONG: begin
          seen   = long_q;
          long_d = 1'b0;
        end
        default: begin
          seen = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_timer_q  <= '0;
      last_level_q    <= 1'b1;
      pressed_q       <= 1'b0;
      count_q         <= '0;
      click_q         <= 1'b0;
      double_q        <= 1'b0;
      long_q          <= 1'b0;
      press_timer_q   <= '0;
      release_timer_q <= '0;
    end else if (step_i) begin
      sample_timer_q  <= sample_timer_d;
      last_level_q    <= last_level_d;
      pressed_q       <= pressed_d;
      count_q         <= count_d;
      click_q         <= click_d;
      double_q        <= double_d;
      long_q          <= long_d;
      press_timer_q   <= press_timer_d;
      release_timer_q <= release_timer_d;
    end
  end

  assign res_o = '{event_seen:     seen,
                   pressed:        pressed_d,
                   click_pending:  click_d,
                   double_pending: double_d,
                   long_pending:   long_d};

  // Only one of the two timers runs at a time
  a_press_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pressed_q |-> press_timer_q == '0)
    else $error("press timer running while released");

  a_release_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressed_q |-> release_timer_q == '0)
    else $error("release timer running while pressed");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.op == OP_READ && item_i.event_select == EV_CLICK |=> !click_q)
    else $error("click flag survived its read");

endmodule

[hw/rtl/button_click_classifier.sv]
// Top level of the button click classifier: input register, configuration
// registers, classifier core and result register. Uses bcc_pkg, bcc_if, bcc_core.

// Each input transaction is either a scan tick (the pin level is debounced,
// press and release times are tracked, clicks are classified) or a read that
// returns one sticky event flag and clears it; every transaction gives exactly
// one result carrying the debounced state and all flags after it. The block
// takes one transaction per clock unless the output side stalls. An accepted
// transaction is held in the input register until the core applies it to the
// state, and its result is loaded into the result register at the same edge
// at which the core state is updated. The input register refills in the cycle
// it drains.
// Configuration writes are always accepted (ready is tied high); index 3 is
// ignored.

module button_click_classifier import bcc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  bcc_in_if.sink    in_i,
  bcc_out_if.source out_o,
  bcc_cfg_if.sink   cfg_i
);

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;
  logic  step;
  cfg_t  cfg_q;
  res_t  core_res;

  // Process the held transaction when the result register is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= '{op: in_i.op, pin_level: in_i.pin_level,
                     event_select: in_i.event_select};
    end
  end

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_period  <= DebounceReset;
      cfg_q.long_press_ticks <= LongReset;
      cfg_q.settle_ticks     <= SettleReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEBOUNCE: cfg_q.debounce_period  <= cfg_i.data;
        REG_LONG:     cfg_q.long_press_ticks <= cfg_i.data;
        REG_SETTLE:   cfg_q.settle_ticks     <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  bcc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.event_seen     = out_res_q.event_seen;
  assign out_o.pressed        = out_res_q.pressed;
  assign out_o.click_pending  = out_res_q.click_pending;
  assign out_o.double_pending = out_res_q.double_pending;
  assign out_o.long_pending   = out_res_q.long_pending;

  // A processed transaction always leaves a result behind
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed transaction produced no result");

  // A held transaction is not dropped while the result side stalls
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q)
    else $error("held transaction lost");

  // Nothing is processed into an occupied, stalled result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !step)
    else $error("result overwritten before it was taken");

endmodule
